FILE: hdl/fba_pkg.sv
package fba_pkg;

    localparam int FRAME_W = 12;
    localparam int CFG_W   = 13;

    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_MARK  = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;
    localparam logic [1:0] REQ_CHECK = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FIND,
        ST_RMW,
        ST_DONE
    } state_t;

endpackage

FILE: hdl/fba_if.sv
interface fba_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [fba_pkg::FRAME_W-1:0] frame_number;

    modport source (output valid, output req_type, output frame_number, input ready);
    modport sink (input valid, input req_type, input frame_number, output ready);
endinterface

interface fba_res_if;
    logic                      valid;
    logic                      ready;
    logic [fba_pkg::FRAME_W-1:0] frame_index;
    logic                      found;
    logic                      was_used;

    modport source (output valid, output frame_index, output found, output was_used,
                    input ready);
    modport sink (input valid, input frame_index, input found, input was_used,
                  output ready);
endinterface

interface fba_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [fba_pkg::CFG_W-1:0] frames_in_use;

    modport source (output valid, output frames_in_use, input ready);
    modport sink (input valid, input frames_in_use, output ready);
endinterface

FILE: hdl/frame_bitmap_allocator.sv
// Channel  Role  Beat contents
// cfg      sink  frames_in_use
// req      sink  req_type, frame_number
// res      src   frame_index, found, was_used
//
// Mark, free and check go from accept to result by word read, modify, write; check skips the write.
// Allocate scans from word 0 up to the first word that is not full, or up to the limit when
// none is free; one bitmap word is read per cycle through the RAM read port.
// After reset a clearing pass writes zero to all NUM_WORDS words, one a cycle,
// while req is not ready. The result register lets the next request in while res stalls.
module frame_bitmap_allocator #(
    parameter int MAX_FRAMES = 4096,
    parameter int WORD_BITS  = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    fba_cfg_if.sink   cfg,
    fba_req_if.sink   req,
    fba_res_if.source res
);

    // WORD_BITS must be a power of two; the block itself does not enforce it.
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W     = $clog2(NUM_WORDS + 1);
    localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

    fba_pkg::state_t state_reg, state_next;

    logic [fba_pkg::CFG_W-1:0]   frames_reg;
    logic [1:0]                  type_reg;
    logic [fba_pkg::FRAME_W-1:0] frame_reg;
    logic [ADDR_W-1:0]           scan_reg;
    logic [ADDR_W-1:0]           clr_reg;
    logic [CNT_W-1:0]            lim_reg;
    logic [WORD_BITS-1:0]        word_reg;
    logic [fba_pkg::FRAME_W-1:0] res_index_reg;
    logic                        res_found_reg;
    logic                        res_was_reg;
    logic                        out_valid_reg;
    logic [fba_pkg::FRAME_W-1:0] out_index_reg;
    logic                        out_found_reg;
    logic                        out_was_reg;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [WORD_BITS-1:0]        ram_wdata;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [WORD_BITS-1:0]        ram_rdata;

    logic [BIT_W-1:0]            ffz_pos;
    logic [31:0]                 in_frame_ext;
    logic [31:0]                 reg_frame_ext;
    logic [ADDR_W-1:0]           in_word;
    logic [ADDR_W-1:0]           reg_word;
    logic                        in_frame_ok;
    logic [BIT_W-1:0]            reg_bit;
    logic [WORD_BITS-1:0]        reg_mask;
    logic [WORD_BITS-1:0]        ffz_mask;
    logic [fba_pkg::CFG_W-1:0]   cfg_words;
    logic [CNT_W-1:0]            lim_comb;
    logic [CNT_W-1:0]            scan_inc;
    logic                        scan_last;
    logic                        clr_last;
    logic                        accept;
    logic                        out_free;
    logic [31:0]                 grant_ext;

    assign in_frame_ext  = 32'(req.frame_number);
    assign reg_frame_ext = 32'(frame_reg);
    assign in_word       = in_frame_ext[BIT_W +: ADDR_W];
    assign reg_word      = reg_frame_ext[BIT_W +: ADDR_W];
    assign in_frame_ok   = (in_frame_ext < 32'(MAX_FRAMES));
    assign reg_bit       = frame_reg[BIT_W-1:0];
    assign reg_mask      = WORD_BITS'(1) << reg_bit;
    assign ffz_mask      = WORD_BITS'(1) << ffz_pos;
    assign cfg_words     = frames_reg >> BIT_W;
    assign lim_comb      = (32'(cfg_words) > 32'(NUM_WORDS)) ? CNT_W'(NUM_WORDS)
                                                             : CNT_W'(cfg_words);
    assign scan_inc      = CNT_W'(scan_reg) + CNT_W'(1);
    assign scan_last     = (scan_inc == lim_reg);
    assign clr_last      = (clr_reg == ADDR_W'(NUM_WORDS - 1));
    assign accept        = req.valid && req.ready;
    assign out_free      = !out_valid_reg || res.ready;
    assign grant_ext     = 32'({scan_reg, ffz_pos});

    assign req.ready       = (state_reg == fba_pkg::ST_IDLE);
    assign cfg.ready       = 1'b1;
    assign res.valid       = out_valid_reg;
    assign res.frame_index = out_index_reg;
    assign res.found       = out_found_reg;
    assign res.was_used    = out_was_reg;

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS),
        .AW    (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fba_ffz #(
        .WIDTH (WORD_BITS),
        .PW    (BIT_W)
    ) u_ffz (
        .word (word_reg),
        .pos  (ffz_pos)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fba_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = fba_pkg::ST_IDLE;
                end
            end
            fba_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.req_type == fba_pkg::REQ_ALLOC)
                    begin
                        state_next = (lim_comb == '0) ? fba_pkg::ST_DONE : fba_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = in_frame_ok ? fba_pkg::ST_RMW : fba_pkg::ST_DONE;
                    end
                end
            end
            fba_pkg::ST_SCAN:
            begin
                if (ram_rdata != FULL_WORD)
                begin
                    state_next = fba_pkg::ST_FIND;
                end
                else if (scan_last)
                begin
                    state_next = fba_pkg::ST_DONE;
                end
            end
            fba_pkg::ST_FIND:
            begin
                state_next = fba_pkg::ST_DONE;
            end
            fba_pkg::ST_RMW:
            begin
                state_next = fba_pkg::ST_DONE;
            end
            fba_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = fba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fba_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (state_reg)
            fba_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            fba_pkg::ST_IDLE:
            begin
                ram_re    = req.valid;
                ram_raddr = (req.req_type == fba_pkg::REQ_ALLOC) ? '0 : in_word;
            end
            fba_pkg::ST_SCAN:
            begin
                ram_re    = (ram_rdata == FULL_WORD) && !scan_last;
                ram_raddr = ADDR_W'(scan_inc);
            end
            fba_pkg::ST_FIND:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg;
                ram_wdata = word_reg | ffz_mask;
            end
            fba_pkg::ST_RMW:
            begin
                ram_waddr = reg_word;
                if (type_reg == fba_pkg::REQ_MARK)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | reg_mask;
                end
                else if (type_reg == fba_pkg::REQ_FREE)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~reg_mask;
                end
            end
            fba_pkg::ST_DONE:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fba_pkg::ST_CLEAR;
            clr_reg       <= '0;
            frames_reg    <= fba_pkg::CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == fba_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (cfg.valid && cfg.ready)
            begin
                frames_reg <= cfg.frames_in_use;
            end
            if (state_reg == fba_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg      <= req.req_type;
            frame_reg     <= req.frame_number;
            lim_reg       <= lim_comb;
            scan_reg      <= '0;
            res_was_reg   <= 1'b0;
            if (req.req_type == fba_pkg::REQ_ALLOC)
            begin
                res_index_reg <= '0;
                res_found_reg <= 1'b0;
            end
            else
            begin
                res_index_reg <= req.frame_number;
                res_found_reg <= 1'b1;
            end
        end
        if (state_reg == fba_pkg::ST_SCAN)
        begin
            word_reg <= ram_rdata;
            if (ram_rdata == FULL_WORD && !scan_last)
            begin
                scan_reg <= ADDR_W'(scan_inc);
            end
        end
        if (state_reg == fba_pkg::ST_FIND)
        begin
            res_index_reg <= grant_ext[fba_pkg::FRAME_W-1:0];
            res_found_reg <= 1'b1;
        end
        if (state_reg == fba_pkg::ST_RMW)
        begin
            res_was_reg <= ram_rdata[reg_bit];
        end
        if (state_reg == fba_pkg::ST_DONE && out_free)
        begin
            out_index_reg <= res_index_reg;
            out_found_reg <= res_found_reg;
            out_was_reg   <= res_was_reg;
        end
    end

endmodule

FILE: hdl/fba_ram.sv
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/fba_ffz.sv
module fba_ffz #(
    parameter int WIDTH = 32,
    parameter int PW    = $clog2(WIDTH)
) (
    input  logic [WIDTH-1:0] word,
    output logic [PW-1:0]    pos
);

    // Lowest clear bit wins; the caller only asks when at least one bit is clear.
    always_comb
    begin
        pos = '0;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                pos = PW'(i);
            end
        end
    end

endmodule

FILE: hdl/fba_chk.sv
module fba_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [fba_pkg::FRAME_W-1:0] res_frame_index,
    input logic                        res_found,
    input logic                        res_was_used
);

    logic [1:0] pending_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = req_valid && req_ready;
    assign out_beat = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_beat && !out_beat)
        begin
            pending_reg <= pending_reg + 2'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_found |-> res_frame_index == '0 && !res_was_used)
        else $error("a failed allocation must report frame zero, not used");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !req_ready)
        else $error("request taken while another is in progress");

    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat |-> pending_reg != 2'd0) && pending_reg != 2'd3)
        else $error("result beats do not match request beats");

endmodule

bind frame_bitmap_allocator fba_chk u_fba_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_frame_index (res.frame_index),
    .res_found       (res.found),
    .res_was_used    (res.was_used)
);
